// ===== hw/rtl/m3inv_pkg.sv =====
// ----------------------------------------------------------------------------
// m3inv_pkg: shared types for the 3x3 matrix inverse core
// beat struct passed between the front and the back part
// ----------------------------------------------------------------------------
package m3inv_pkg;

  localparam int unsigned NUM_ELEMS = 9;

  // front-to-back status flags for one beat
  typedef struct packed {
    logic singular;
    logic det_neg;
  } beat_flags_t;

endpackage

// ===== hw/rtl/matrix3_inverse_core.sv =====
// ----------------------------------------------------------------------------
// matrix3_inverse_core: 3x3 fixed-point matrix inverse by adjugate
//
//  channel | signals                              | dir
//  in      | in_valid, in_ready, elem_0..elem_8   | into block
//  out     | out_valid, out_ready, inv_0..inv_8,  | out of block
//          | determinant, singular                |
//
// one matrix per cycle sustained while the output is not stalled; a beat passes the front
// pipeline, then the queue, then the back stages set by the one-bit-per-stage divider
// synchronous active-high reset clears all valid bits, no clearing pass
// front and back stall separately, a two-beat queue parts them
// ----------------------------------------------------------------------------
module matrix3_inverse_core #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ELEM_WIDTH-1:0] elem_0,
  input  logic signed [ELEM_WIDTH-1:0] elem_1,
  input  logic signed [ELEM_WIDTH-1:0] elem_2,
  input  logic signed [ELEM_WIDTH-1:0] elem_3,
  input  logic signed [ELEM_WIDTH-1:0] elem_4,
  input  logic signed [ELEM_WIDTH-1:0] elem_5,
  input  logic signed [ELEM_WIDTH-1:0] elem_6,
  input  logic signed [ELEM_WIDTH-1:0] elem_7,
  input  logic signed [ELEM_WIDTH-1:0] elem_8,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [ELEM_WIDTH-1:0] inv_0,
  output logic signed [ELEM_WIDTH-1:0] inv_1,
  output logic signed [ELEM_WIDTH-1:0] inv_2,
  output logic signed [ELEM_WIDTH-1:0] inv_3,
  output logic signed [ELEM_WIDTH-1:0] inv_4,
  output logic signed [ELEM_WIDTH-1:0] inv_5,
  output logic signed [ELEM_WIDTH-1:0] inv_6,
  output logic signed [ELEM_WIDTH-1:0] inv_7,
  output logic signed [ELEM_WIDTH-1:0] inv_8,
  output logic signed [ELEM_WIDTH-1:0] determinant,
  output logic                         singular
);

  localparam int unsigned CW = 2 * ELEM_WIDTH + 1;
  localparam int unsigned DW = 3 * ELEM_WIDTH + 3;
  localparam int unsigned QW = 9 * CW + DW + 2;

  logic signed [ELEM_WIDTH-1:0] m_in [9];
  logic signed [CW-1:0]         f_adj [9];
  logic signed [DW-1:0]         f_det;
  m3inv_pkg::beat_flags_t       f_flags;
  logic                         f_valid, f_ready;
  logic                         q_valid, q_ready;
  logic [QW-1:0]                q_in, q_out;
  logic signed [CW-1:0]         b_adj [9];
  logic signed [DW-1:0]         b_det;
  m3inv_pkg::beat_flags_t       b_flags;
  logic signed [ELEM_WIDTH-1:0] inv [9];

  assign m_in = '{elem_0, elem_1, elem_2, elem_3, elem_4, elem_5, elem_6, elem_7, elem_8};

  // cofactors and determinant
  m3inv_front #(.ELEM_WIDTH(ELEM_WIDTH), .CW(CW), .DW(DW)) u_front (
    .clk, .rst, .in_valid, .in_ready, .m_in,
    .out_valid(f_valid), .out_ready(f_ready),
    .adj_out(f_adj), .det_out(f_det), .flags_out(f_flags)
  );

  // pack a front beat into the queue word and unpack the queue word for the back
  always_comb begin
    q_in = {f_flags, f_det, f_adj[0], f_adj[1], f_adj[2], f_adj[3], f_adj[4],
            f_adj[5], f_adj[6], f_adj[7], f_adj[8]};
    {b_flags, b_det, b_adj[0], b_adj[1], b_adj[2], b_adj[3], b_adj[4],
     b_adj[5], b_adj[6], b_adj[7], b_adj[8]} = q_out;
  end

  m3inv_queue #(.W(QW)) u_queue (
    .clk, .rst, .in_valid(f_valid), .in_ready(f_ready), .in_data(q_in),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_out)
  );

  // division, rounding and saturation
  m3inv_back #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS), .CW(CW), .DW(DW)) u_back (
    .clk, .rst, .in_valid(q_valid), .in_ready(q_ready),
    .adj_in(b_adj), .det_in(b_det), .flags_in(b_flags),
    .out_valid, .out_ready, .inv, .det_q(determinant), .singular
  );

  assign inv_0 = inv[0];
  assign inv_1 = inv[1];
  assign inv_2 = inv[2];
  assign inv_3 = inv[3];
  assign inv_4 = inv[4];
  assign inv_5 = inv[5];
  assign inv_6 = inv[6];
  assign inv_7 = inv[7];
  assign inv_8 = inv[8];

`ifndef SYNTHESIS
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> inv_0 == '0 && inv_4 == '0 && inv_8 == '0)
    else $error("singular beat with nonzero inverse");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(determinant))
    else $error("stalled result changed");
  a_sing_det: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> determinant == '0)
    else $error("singular beat with nonzero determinant");
`endif

endmodule

// ===== hw/rtl/m3inv_front.sv =====
// ----------------------------------------------------------------------------
// m3inv_front: cofactor and determinant pipeline
// takes one matrix per cycle while its output is not stalled, forms the adjugate and exact determinant
// ----------------------------------------------------------------------------
module m3inv_front #(
  parameter int unsigned ELEM_WIDTH = 32,
  parameter int unsigned CW = 2 * ELEM_WIDTH + 1,
  parameter int unsigned DW = 3 * ELEM_WIDTH + 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ELEM_WIDTH-1:0] m_in [9],
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [CW-1:0]         adj_out [9],
  output logic signed [DW-1:0]         det_out,
  output m3inv_pkg::beat_flags_t       flags_out
);

  localparam int unsigned PW = 2 * ELEM_WIDTH;

  logic                         v1, v2, v3, v4, adv;
  logic signed [ELEM_WIDTH-1:0] m1 [9];
  logic signed [PW-1:0]         pa [9];
  logic signed [PW-1:0]         pb [9];
  logic signed [ELEM_WIDTH-1:0] r2 [3];
  logic signed [ELEM_WIDTH-1:0] r3 [3];
  logic signed [CW-1:0]         adj2 [9];
  logic signed [CW-1:0]         adj3 [9];
  logic signed [CW-1:0]         ph [3];
  logic signed [CW-1:0]         pl [3];
  logic signed [DW-1:0]         dsum;

  // the whole pipe moves as one unit
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; out_valid <= v4;
    end
  end

  // first-row expansion from split partial products
  always_comb begin
    dsum = '0;
    for (int k = 0; k < 3; k++) begin
      dsum = dsum + (DW'(ph[k]) <<< ELEM_WIDTH) + DW'(pl[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1 <= m_in;
      pa[0] <= m1[4] * m1[8]; pb[0] <= m1[5] * m1[7];
      pa[1] <= m1[2] * m1[7]; pb[1] <= m1[1] * m1[8];
      pa[2] <= m1[1] * m1[5]; pb[2] <= m1[2] * m1[4];
      pa[3] <= m1[5] * m1[6]; pb[3] <= m1[3] * m1[8];
      pa[4] <= m1[0] * m1[8]; pb[4] <= m1[2] * m1[6];
      pa[5] <= m1[2] * m1[3]; pb[5] <= m1[0] * m1[5];
      pa[6] <= m1[3] * m1[7]; pb[6] <= m1[4] * m1[6];
      pa[7] <= m1[1] * m1[6]; pb[7] <= m1[0] * m1[7];
      pa[8] <= m1[0] * m1[4]; pb[8] <= m1[1] * m1[3];
      r2 <= m1[0:2];
      for (int i = 0; i < 9; i++) begin
        adj2[i] <= CW'(pa[i]) - CW'(pb[i]);
      end
      r3 <= r2;
      adj3 <= adj2;
      // row element times cofactor, cofactor split into high and low halves
      for (int k = 0; k < 3; k++) begin
        ph[k] <= r3[k] * $signed(adj2[3*k][CW-1:ELEM_WIDTH]);
        pl[k] <= r3[k] * $signed({1'b0, adj2[3*k][ELEM_WIDTH-1:0]});
      end
      adj_out <= adj3;
      det_out <= dsum;
      flags_out.singular <= dsum == '0;
      flags_out.det_neg  <= dsum[DW-1];
    end
  end

`ifndef SYNTHESIS
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("front stalls with empty output");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("front dropped a beat");
  a_sing: assert property (@(posedge clk) disable iff (rst)
    out_valid && flags_out.singular |-> !flags_out.det_neg)
    else $error("singular with negative det");
`endif

endmodule

// ===== hw/rtl/m3inv_queue.sv =====
// ----------------------------------------------------------------------------
// m3inv_queue: two-entry skid queue between front and back
// ----------------------------------------------------------------------------
module m3inv_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic [W-1:0] mem [2];
  logic         wp, rp;
  logic [1:0]   cnt;

  assign in_ready  = cnt != 2'd2;
  assign out_valid = cnt != 2'd0;
  assign out_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= !wp;
      if (out_valid && out_ready) rp <= !rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= in_data;
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count out of range");
  a_full: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd2 && !out_ready |=> cnt == 2'd2) else $error("queue lost a beat");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd0 && !in_valid |=> cnt == 2'd0) else $error("queue invented a beat");
`endif

endmodule

// ===== hw/rtl/m3inv_back.sv =====
// ----------------------------------------------------------------------------
// m3inv_back: pipelined restoring dividers and output saturation
// one quotient bit per stage, nine lanes plus determinant rounding
// ----------------------------------------------------------------------------
module m3inv_back #(
  parameter int unsigned ELEM_WIDTH = 32,
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned CW = 2 * ELEM_WIDTH + 1,
  parameter int unsigned DW = 3 * ELEM_WIDTH + 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [CW-1:0]         adj_in [9],
  input  logic signed [DW-1:0]         det_in,
  input  m3inv_pkg::beat_flags_t       flags_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [ELEM_WIDTH-1:0] inv [9],
  output logic signed [ELEM_WIDTH-1:0] det_q,
  output logic                         singular
);

  // quotient is ELEM_WIDTH+1 bits after which it saturates anyway
  localparam int unsigned QB = ELEM_WIDTH + 1;
  localparam int unsigned NS = QB;
  localparam int unsigned RW = DW + 2;
  localparam int unsigned NW = CW + 2 * FRAC_BITS + 1;
  localparam int unsigned OW = NW + QB + 2;
  localparam logic [ELEM_WIDTH-1:0] MAXP = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
  localparam logic [ELEM_WIDTH-1:0] MAXN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QB-1:0] q;
    logic          ovf;
    logic          neg;
  } lane_t;

  logic                  adv;
  logic                  vs [NS+1];
  lane_t                 ln [NS+1][9];
  logic [RW-1:0]         dd [NS+1];
  logic signed [ELEM_WIDTH-1:0] ds [NS+1];
  logic                  sg [NS+1];
  logic                  ovf_in [9];
  logic [NW-1:0]         num_in [9];
  logic [DW-1:0]         dabs;
  logic [DW:0]           rsum;
  logic [DW:0]           rsh;
  logic signed [ELEM_WIDTH-1:0] dsat;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // determinant rounding and saturation
  always_comb begin
    dabs = det_in[DW-1] ? DW'(-det_in) : DW'(det_in);
    rsum = {1'b0, dabs} + ((DW+1)'(1) << (2 * FRAC_BITS - 1));
    rsh  = rsum >> (2 * FRAC_BITS);
    if (rsh > (DW+1)'(MAXP) + (DW+1)'(flags_in.det_neg))
      dsat = flags_in.det_neg ? MAXN : MAXP;
    else
      dsat = flags_in.det_neg ? ELEM_WIDTH'(-rsh) : ELEM_WIDTH'(rsh);
  end

  // numerator 2*|C|*2^2F + |D| over divisor 2|D|; quotient high bits checked up front
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      num_in[i] = (NW'(adj_in[i][CW-1] ? -adj_in[i] : adj_in[i]) << (2 * FRAC_BITS + 1))
                  + NW'(dabs);
      // overflow if num >= 2|D| * 2^QB
      ovf_in[i] = OW'(num_in[i]) >= (OW'(dabs) << (QB + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= NS; s++) vs[s] <= 1'b0;
    end else if (adv) begin
      vs[0] <= in_valid;
      for (int s = 1; s <= NS; s++) vs[s] <= vs[s-1];
    end
  end

  assign out_valid = vs[NS];

  // stage 0 preloads remainder with numerator bits above the quotient window
  always_ff @(posedge clk) begin
    if (adv) begin
      dd[0] <= RW'({dabs, 1'b0});
      ds[0] <= dsat;
      sg[0] <= flags_in.singular;
      for (int i = 0; i < 9; i++) begin
        ln[0][i].rem <= RW'(num_in[i] >> QB);
        ln[0][i].q   <= num_in[i][QB-1:0];
        ln[0][i].ovf <= ovf_in[i];
        ln[0][i].neg <= adj_in[i][CW-1] ^ flags_in.det_neg;
      end
      for (int s = 1; s <= NS; s++) begin
        dd[s] <= dd[s-1];
        ds[s] <= ds[s-1];
        sg[s] <= sg[s-1];
      end
    end
  end

  // the low QB numerator bits ride along in the quotient field and shift out
  genvar gs, gi;
  generate
    for (gs = 1; gs <= NS; gs++) begin : g_stage
      for (gi = 0; gi < 9; gi++) begin : g_lane
        logic [RW-1:0] trial;
        logic          nb;
        always_comb begin
          nb    = ln[gs-1][gi].q[QB-1];
          trial = {ln[gs-1][gi].rem[RW-2:0], nb};
        end
        always_ff @(posedge clk) begin
          if (adv) begin
            ln[gs][gi].ovf <= ln[gs-1][gi].ovf;
            ln[gs][gi].neg <= ln[gs-1][gi].neg;
            if (trial >= dd[gs-1]) begin
              ln[gs][gi].rem <= trial - dd[gs-1];
              ln[gs][gi].q   <= {ln[gs-1][gi].q[QB-2:0], 1'b1};
            end else begin
              ln[gs][gi].rem <= trial;
              ln[gs][gi].q   <= {ln[gs-1][gi].q[QB-2:0], 1'b0};
            end
          end
        end
      end
    end
  endgenerate

  logic [QB-1:0] qfull [9];
  always_comb begin
    for (int i = 0; i < 9; i++) qfull[i] = ln[NS][i].q;
  end

  always_comb begin
    det_q    = ds[NS];
    singular = sg[NS];
    for (int i = 0; i < 9; i++) begin
      if (sg[NS]) inv[i] = '0;
      else if (ln[NS][i].ovf || qfull[i] > QB'(MAXP) + QB'(ln[NS][i].neg))
        inv[i] = ln[NS][i].neg ? MAXN : MAXP;
      else
        inv[i] = ln[NS][i].neg ? ELEM_WIDTH'(-qfull[i]) : ELEM_WIDTH'(qfull[i]);
    end
  end

`ifndef SYNTHESIS
  a_sing0: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> det_q == '0) else $error("singular with nonzero det");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("back dropped a beat");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("back stalls while empty");
`endif

endmodule

// ===== verif/matrix3_inverse_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_checker: scoreboard for the 3x3 inverse core
// predicts inverse, determinant and singular flag from each input beat using
// exact 128-bit integer math, and compares every output beat in order
// ----------------------------------------------------------------------------
module matrix3_inverse_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  logic [287:0]  elems,
  input  logic          out_valid,
  input  logic          out_ready,
  input  logic [287:0]  invs,
  input  logic [31:0]   det_out,
  input  logic          sing_out,
  output int            mismatches,
  output int            pending
);

  localparam int FRAC = 16;

  typedef struct packed {
    logic [8:0][31:0] inv;
    logic [31:0]      det;
    logic             sing;
  } inverse_t;

  inverse_t inverse_q[$];

  function automatic logic [31:0] clamp32(logic [127:0] mag, bit neg);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (mag > lim) mag = lim;
    return neg ? -mag[31:0] : mag[31:0];
  endfunction

  function automatic inverse_t predict_inverse(logic [287:0] e);
    logic signed [127:0] m [9];
    logic signed [127:0] adj [9];
    logic signed [127:0] d;
    logic [127:0] dabs, num, q;
    inverse_t r;
    for (int i = 0; i < 9; i++) m[i] = $signed(e[i*32 +: 32]);
    adj[0] = m[4]*m[8] - m[5]*m[7];
    adj[1] = m[2]*m[7] - m[1]*m[8];
    adj[2] = m[1]*m[5] - m[2]*m[4];
    adj[3] = m[5]*m[6] - m[3]*m[8];
    adj[4] = m[0]*m[8] - m[2]*m[6];
    adj[5] = m[2]*m[3] - m[0]*m[5];
    adj[6] = m[3]*m[7] - m[4]*m[6];
    adj[7] = m[1]*m[6] - m[0]*m[7];
    adj[8] = m[0]*m[4] - m[1]*m[3];
    d = m[0]*adj[0] + m[1]*adj[3] + m[2]*adj[6];
    dabs = d < 0 ? -d : d;
    r.det = clamp32((dabs + (128'd1 << (2*FRAC-1))) >> (2*FRAC), d < 0);
    r.sing = (d == 0);
    for (int i = 0; i < 9; i++) begin
      if (d == 0) begin
        r.inv[i] = '0;
      end else begin
        num = (adj[i] < 0 ? -adj[i] : adj[i]);
        num = num << (2*FRAC);
        // round half away from zero on the magnitude
        q = ((num << 1) + dabs) / (dabs << 1);
        r.inv[i] = clamp32(q, (adj[i] < 0) != (d < 0));
      end
    end
    if (d == 0) r.det = '0;
    return r;
  endfunction

  always @(posedge clk) begin
    inverse_t got, want;
    if (rst) begin
      inverse_q.delete();
      mismatches <= 0;
    end else begin
      if (in_valid && in_ready) inverse_q.push_back(predict_inverse(elems));
      if (out_valid && out_ready) begin
        got.inv = invs;
        got.det = det_out;
        got.sing = sing_out;
        if (inverse_q.size() == 0) begin
          $display("%0t: unexpected output beat det=%h", $time, det_out);
          mismatches <= mismatches + 1;
        end else begin
          want = inverse_q.pop_front();
          if (got !== want) begin
            for (int i = 0; i < 9; i++)
              if (got.inv[i] !== want.inv[i])
                $display("%0t: inv_%0d expected %h actual %h", $time, i,
                         want.inv[i], got.inv[i]);
            if (got.det !== want.det)
              $display("%0t: determinant expected %h actual %h", $time,
                       want.det, got.det);
            if (got.sing !== want.sing)
              $display("%0t: singular expected %b actual %b", $time,
                       want.sing, got.sing);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    pending <= inverse_q.size();
  end

  initial begin
    mismatches = 0;
    pending = 0;
  end

endmodule

// ===== verif/matrix3_inverse_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_core_tb: stimulus and verdict for the 3x3 inverse core
// directed corner matrices, then random offset-diagonal, raw, singular, tiny,
// near-extreme, small matrices under bursty input and patterned output stalls
// ----------------------------------------------------------------------------
module matrix3_inverse_core_tb;

  localparam logic [31:0] ONE     = 32'h0001_0000;
  localparam logic [31:0] MAX_POS = 32'h7fff_ffff;
  localparam logic [31:0] MAX_NEG = 32'h8000_0000;
  localparam int RANDOM_BEATS = 1700;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [8:0][31:0] mat = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] inv [9];
  logic signed [31:0] determinant;
  logic singular;
  int mismatches, pending;
  int cycles = 0;
  bit long_hold = 0;   // request a long receiver stall
  bit sending = 1;

  always #6 clk = ~clk;

  matrix3_inverse_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .elem_0(mat[0]), .elem_1(mat[1]), .elem_2(mat[2]),
    .elem_3(mat[3]), .elem_4(mat[4]), .elem_5(mat[5]),
    .elem_6(mat[6]), .elem_7(mat[7]), .elem_8(mat[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .inv_0(inv[0]), .inv_1(inv[1]), .inv_2(inv[2]),
    .inv_3(inv[3]), .inv_4(inv[4]), .inv_5(inv[5]),
    .inv_6(inv[6]), .inv_7(inv[7]), .inv_8(inv[8]),
    .determinant(determinant), .singular(singular)
  );

  matrix3_inverse_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .elems(mat),
    .out_valid(out_valid), .out_ready(out_ready),
    .invs({inv[8], inv[7], inv[6], inv[5], inv[4], inv[3], inv[2], inv[1],
           inv[0]}),
    .det_out(determinant), .sing_out(singular),
    .mismatches(mismatches), .pending(pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: the stall pattern switches between random modes, plus a long hold
  initial begin
    int mode, hold;
    mode = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 0;
        for (hold = 0; hold < 300; hold++) @(posedge clk);
        long_hold = 0;
      end
      if (cycles % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_ready <= 1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= cycles[2];
      endcase
    end
  end

  int burst_left = 0;

  // present one beat and hold it until accepted; gaps fall between bursts
  task automatic send_matrix(logic [8:0][31:0] m);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1;
    mat <= m;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_idle();
    in_valid <= 0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_small();
    return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
  endfunction

  function automatic logic [8:0][31:0] random_matrix();
    logic [8:0][31:0] m;
    int kind;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 9; i++) m[i] = rnd_small();
    if (kind < 25) begin
      // diagonal offset by +8, -8, +8 units of ONE
      m[0] += 8 * ONE; m[4] -= 8 * ONE; m[8] += 8 * ONE;
    end else if (kind < 45) begin
      for (int i = 0; i < 9; i++) m[i] = $urandom();
    end else if (kind < 58) begin
      // singular: repeated row or zero column
      if (kind & 1) begin
        m[6] = m[0]; m[7] = m[1]; m[8] = m[2];
      end else begin
        m[1] = 0; m[4] = 0; m[7] = 0;
      end
    end else if (kind < 66) begin
      // tiny entries, tiny determinant
      for (int i = 0; i < 9; i++) m[i] = $signed($urandom_range(0, 15)) - 8;
    end else if (kind < 72) begin
      for (int i = 0; i < 9; i++)
        m[i] = $urandom_range(0, 1) ? MAX_POS - $urandom_range(0, 3)
                                    : MAX_NEG + $urandom_range(0, 3);
    end
    return m;
  endfunction

  initial begin
    logic [8:0][31:0] m;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed corners
    send_matrix({ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE});
    send_matrix({-ONE, 32'd0, 32'd0, 32'd0, -ONE, 32'd0, 32'd0, 32'd0, -ONE});
    send_matrix('0);
    send_matrix({9{MAX_POS}});
    send_matrix({9{MAX_NEG}});
    send_matrix({9{32'hffff_ffff}});
    send_matrix({MAX_POS, 32'd0, 32'd0, 32'd0, MAX_POS, 32'd0, 32'd0, 32'd0,
                 MAX_POS});
    send_matrix({MAX_NEG, 32'd0, 32'd0, 32'd0, MAX_POS, 32'd0, 32'd0, 32'd0,
                 MAX_NEG});
    send_matrix({32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0,
                 32'd1});
    send_matrix({32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8,
                 32'd10});
    send_matrix({ONE * 2, ONE, 32'd0, ONE, ONE * 2, ONE, 32'd0, ONE, ONE * 2});
    send_matrix({ONE, ONE * 2, ONE * 3, ONE * 2, ONE * 4, ONE * 6, ONE, 32'd0,
                 ONE});
    send_matrix({32'h0000_8000, 32'd0, 32'd0, 32'd0, 32'h0000_8000, 32'd0,
                 32'd0, 32'd0, 32'h0000_8000});
    send_matrix({MAX_POS, MAX_NEG, 32'd0, MAX_NEG, MAX_POS, 32'd1, 32'd1,
                 32'd0, MAX_NEG});
    send_matrix({32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678, 32'hedcb_a987,
                 32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h0000_0003, 32'h7fff_0000,
                 32'h8001_0000});
    drain_idle();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 400) long_hold = 1;
      if (n == 900) drain_idle();
      send_matrix(random_matrix());
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
